// ----- rtl/iirdf_pkg.sv -----
// Shared widths, codes and types of the direct form I IIR filter.
package iirdf_pkg;

  localparam int unsigned MAX_ORDER  = 127;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned COEF_W     = 48;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned ORDER_W    = 7;
  localparam int unsigned FRAC_W     = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  // Coefficient split for the two partial products
  localparam int unsigned COEF_LO_W  = 24;
  localparam int unsigned COEF_HI_W  = COEF_W - COEF_LO_W;
  localparam int unsigned PHI_W      = COEF_HI_W + OUT_W;
  localparam int unsigned PLO_W      = COEF_LO_W + 1 + OUT_W;
  localparam int unsigned PROD_W     = COEF_W + OUT_W;

  // History word: {x, y}
  localparam int unsigned HIST_W     = SAMPLE_W + OUT_W;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd119;
  localparam logic [FRAC_W-1:0]  FRAC_RESET  = 6'd30;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_WR_NUM = 2'd1,
    FUNC_WR_DEN = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 1'b0,
    CFG_FRAC  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN,
    ST_SCALE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SRC_SAMPLE,
    SRC_X,
    SRC_Y
  } src_e;

  // One multiply-accumulate operation issued by the sequencer
  typedef struct packed {
    logic valid;
    src_e src;
    logic neg;
    logic zero;
  } mac_op_t;

endpackage

// ----- rtl/iirdf_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module iirdf_ram #(
  parameter int unsigned Width = iirdf_pkg::COEF_W,
  parameter int unsigned Depth = 2 * (iirdf_pkg::MAX_ORDER + 1),
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/iirdf_mac.sv -----
// Pipelined multiply-accumulate, scaling shift and output saturation.
module iirdf_mac #(
  parameter int unsigned MaxOrder = iirdf_pkg::MAX_ORDER
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_clr_i,
  input  iirdf_pkg::mac_op_t                op_i,
  input  logic [iirdf_pkg::COEF_W-1:0]      coef_i,
  input  logic [iirdf_pkg::HIST_W-1:0]      hist_i,
  input  logic [iirdf_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [iirdf_pkg::FRAC_W-1:0]      frac_i,
  input  logic                              scale_i,
  output logic                              busy_o,
  output logic [iirdf_pkg::OUT_W-1:0]       y_o,
  output logic                              sat_o
);

  localparam int unsigned OutW   = iirdf_pkg::OUT_W;
  localparam int unsigned SampW  = iirdf_pkg::SAMPLE_W;
  localparam int unsigned HistW  = iirdf_pkg::HIST_W;
  localparam int unsigned ProdW  = iirdf_pkg::PROD_W;
  localparam int unsigned PhiW   = iirdf_pkg::PHI_W;
  localparam int unsigned PloW   = iirdf_pkg::PLO_W;
  localparam int unsigned LoW    = iirdf_pkg::COEF_LO_W;
  localparam int unsigned AccW   = ProdW + $clog2(2 * MaxOrder + 2);

  iirdf_pkg::mac_op_t op1_q, op2_q, op3_q;

  logic [iirdf_pkg::COEF_HI_W-1:0] coef_hi;
  logic [LoW-1:0]                  coef_lo;
  logic [OutW-1:0]                 val;
  logic signed [PhiW-1:0]          prod_hi_d, prod_hi_q;
  logic signed [PloW-1:0]          prod_lo_d, prod_lo_q;
  logic [ProdW-1:0]                prod_d, prod_q;
  logic [AccW-1:0]                 prod_ext;
  logic signed [AccW-1:0]          acc_q;
  logic signed [AccW-1:0]          scaled_q;
  logic [AccW-OutW:0]              upper;
  logic                            fits;

  // Operand select, aligned with the RAM read data
  always_comb begin
    case (op1_q.src)
      iirdf_pkg::SRC_SAMPLE: val = {{(OutW-SampW){sample_i[SampW-1]}}, sample_i};
      iirdf_pkg::SRC_X:      val = {{(OutW-SampW){hist_i[HistW-1]}},
                                    hist_i[HistW-1 -: SampW]};
      iirdf_pkg::SRC_Y:      val = hist_i[OutW-1:0];
      default:               val = '0;
    endcase
    if (op1_q.zero) begin
      val = '0;
    end
  end

  assign coef_hi   = coef_i[iirdf_pkg::COEF_W-1:LoW];
  assign coef_lo   = coef_i[LoW-1:0];
  assign prod_hi_d = $signed(coef_hi) * $signed(val);
  assign prod_lo_d = $signed({1'b0, coef_lo}) * $signed(val);

  // Recombine the partial products
  assign prod_d = {prod_hi_q, {LoW{1'b0}}} +
                  {{(ProdW-PloW){prod_lo_q[PloW-1]}}, prod_lo_q};
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= '0;
      op2_q <= '0;
      op3_q <= '0;
    end else begin
      op1_q <= op_i;
      op2_q <= op1_q;
      op3_q <= op2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_hi_q <= prod_hi_d;
    prod_lo_q <= prod_lo_d;
    prod_q    <= prod_d;
    if (acc_clr_i) begin
      acc_q <= '0;
    end else if (op3_q.valid) begin
      if (op3_q.neg) begin
        acc_q <= acc_q - $signed(prod_ext);
      end else begin
        acc_q <= acc_q + $signed(prod_ext);
      end
    end
    if (scale_i) begin
      scaled_q <= acc_q >>> frac_i;
    end
  end

  // Clip to the signed output range
  assign upper = scaled_q[AccW-1:OutW-1];
  assign fits  = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      y_o   = scaled_q[OutW-1:0];
      sat_o = 1'b0;
    end else if (scaled_q[AccW-1]) begin
      y_o   = {1'b1, {(OutW-1){1'b0}}};
      sat_o = 1'b1;
    end else begin
      y_o   = {1'b0, {(OutW-1){1'b1}}};
      sat_o = 1'b1;
    end
  end

  assign busy_o = op1_q.valid | op2_q.valid | op3_q.valid;

`ifndef SYNTHESIS
  a_clr_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_clr_i |-> !busy_o)
    else $error("accumulator cleared with operations in flight");

  a_scale_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_i |-> !busy_o)
    else $error("scaling taken before the accumulator settled");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_o |-> (y_o == {1'b1, {(OutW-1){1'b0}}} || y_o == {1'b0, {(OutW-1){1'b1}}}))
    else $error("saturated word is not a range limit");
`endif

endmodule

// ----- rtl/iir_direct_form_filter_unit.sv -----
// Top level of the direct form I IIR filter: sequencer, registers and memories.
//
//  channel  direction  handshake                   payload
//  in       input      in_valid_i / in_ready_o     func_i, sample_in_i, coef_index_i,
//                                                  coef_value_i
//  out      output     out_valid_o / out_ready_i   filtered_out_o, saturated_o
//  cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// During the tap phase of a sample word, the coefficient memory read port issues one
// tap product per cycle; the taps run up to filter_order capped at MaxOrder.
// Coefficient writes and history clears give no output word.
// Reset empties both histories at once through the fill count and restores the
// register defaults; coefficient contents are undefined until written.
// A finished word waits in the output register; the next sample is taken while
// it waits and stalls only at its own end if the old word is still not taken.
module iir_direct_form_filter_unit #(
  parameter int unsigned MaxOrder = iirdf_pkg::MAX_ORDER
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [iirdf_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [iirdf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [iirdf_pkg::IDX_W-1:0]         coef_index_i,
  input  logic signed [iirdf_pkg::COEF_W-1:0] coef_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [iirdf_pkg::OUT_W-1:0]  filtered_out_o,
  output logic                                saturated_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [iirdf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [iirdf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned CntW      = $clog2(MaxOrder + 1);
  localparam int unsigned CoefIdxW  = CntW;
  localparam int unsigned CoefDepth = 2 ** (CoefIdxW + 1);
  localparam int unsigned HptrW     = (MaxOrder > 1) ? $clog2(MaxOrder) : 1;
  localparam int unsigned HistW     = iirdf_pkg::HIST_W;
  localparam int unsigned OutW      = iirdf_pkg::OUT_W;

  iirdf_pkg::state_e  state_q, state_d;
  iirdf_pkg::func_e   func_in;
  iirdf_pkg::mac_op_t op;

  logic [CntW-1:0]  tap_q, tap_d;
  logic             phase_q, phase_d;
  logic [HptrW-1:0] ptr_q, ptr_d;
  logic [HptrW-1:0] head_q, head_d;
  logic [HptrW-1:0] new_head;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [CntW-1:0]  ord_eff;

  logic [iirdf_pkg::ORDER_W-1:0]  order_q;
  logic [iirdf_pkg::FRAC_W-1:0]   frac_q;
  logic [iirdf_pkg::SAMPLE_W-1:0] sample_q;

  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic            out_sat_q;
  logic            out_free;
  logic            out_load;

  logic in_fire;
  logic cfg_fire;
  logic idx_ok;
  logic acc_clr;
  logic scale_en;
  logic mac_busy;
  logic [OutW-1:0] mac_y;
  logic            mac_sat;

  logic                  coef_we, coef_re;
  logic [CoefIdxW:0]     coef_waddr, coef_raddr;
  logic [iirdf_pkg::COEF_W-1:0] coef_rdata;

  logic             hist_we, hist_re;
  logic [HptrW-1:0] hist_waddr, hist_raddr;
  logic [HistW-1:0] hist_wdata, hist_rdata;

  assign func_in  = iirdf_pkg::func_e'(func_i);
  assign in_ready_o = (state_q == iirdf_pkg::ST_IDLE);
  assign in_fire  = in_valid_i & in_ready_o;
  assign idx_ok   = (32'(coef_index_i) <= MaxOrder);
  assign ord_eff  = (32'(order_q) > MaxOrder) ? CntW'(MaxOrder) : CntW'(order_q);
  assign out_free = ~out_valid_q | out_ready_i;
  assign new_head = (head_q == '0) ? HptrW'(MaxOrder - 1) : head_q - 1'b1;

  // Take configuration only between items; a write at the edge that takes a
  // sample already applies to that sample
  assign cfg_ready_o = (state_q == iirdf_pkg::ST_IDLE);
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= iirdf_pkg::ORDER_RESET;
      frac_q  <= iirdf_pkg::FRAC_RESET;
    end else if (cfg_fire) begin
      case (iirdf_pkg::cfg_idx_e'(cfg_index_i))
        iirdf_pkg::CFG_ORDER: order_q <= cfg_data_i[iirdf_pkg::ORDER_W-1:0];
        iirdf_pkg::CFG_FRAC:  frac_q  <= cfg_data_i[iirdf_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iirdf_pkg::ST_IDLE: begin
        if (in_fire && func_in == iirdf_pkg::FUNC_SAMPLE) begin
          state_d = iirdf_pkg::ST_TAP;
        end
      end
      iirdf_pkg::ST_TAP: begin
        if (!phase_q && tap_q == '0 && ord_eff == '0) begin
          state_d = iirdf_pkg::ST_DRAIN;
        end else if (phase_q && tap_q == ord_eff) begin
          state_d = iirdf_pkg::ST_DRAIN;
        end
      end
      iirdf_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = iirdf_pkg::ST_SCALE;
        end
      end
      iirdf_pkg::ST_SCALE: state_d = iirdf_pkg::ST_DONE;
      iirdf_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = iirdf_pkg::ST_IDLE;
        end
      end
      default: state_d = iirdf_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and counters
  always_comb begin
    tap_d      = tap_q;
    phase_d    = phase_q;
    ptr_d      = ptr_q;
    head_d     = head_q;
    fill_d     = fill_q;
    op         = '0;
    op.src     = iirdf_pkg::SRC_SAMPLE;
    acc_clr    = 1'b0;
    scale_en   = 1'b0;
    out_load   = 1'b0;
    coef_we    = 1'b0;
    coef_waddr = {1'b0, CoefIdxW'(coef_index_i)};
    coef_re    = 1'b0;
    coef_raddr = {1'b0, tap_q};
    hist_we    = 1'b0;
    hist_waddr = new_head;
    hist_wdata = {sample_q, mac_y};
    hist_re    = 1'b0;
    hist_raddr = ptr_q;
    case (state_q)
      iirdf_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (func_in)
            iirdf_pkg::FUNC_SAMPLE: begin
              tap_d   = '0;
              phase_d = 1'b0;
              ptr_d   = head_q;
              acc_clr = 1'b1;
            end
            iirdf_pkg::FUNC_WR_NUM: begin
              coef_we = idx_ok;
            end
            iirdf_pkg::FUNC_WR_DEN: begin
              coef_we    = idx_ok && (coef_index_i != '0);
              coef_waddr = {1'b1, CoefIdxW'(coef_index_i)};
            end
            iirdf_pkg::FUNC_CLEAR: begin
              head_d = '0;
              fill_d = '0;
            end
            default: ;
          endcase
        end
      end
      iirdf_pkg::ST_TAP: begin
        op.valid = 1'b1;
        coef_re  = 1'b1;
        if (!phase_q) begin
          coef_raddr = {1'b0, tap_q};
          if (tap_q == '0) begin
            // b[0] times the new sample
            op.src = iirdf_pkg::SRC_SAMPLE;
            tap_d  = CntW'(1);
          end else begin
            op.src  = iirdf_pkg::SRC_X;
            op.zero = (tap_q > fill_q);
            hist_re = 1'b1;
            phase_d = 1'b1;
          end
        end else begin
          // feedback term reuses the history word read in the previous cycle
          coef_raddr = {1'b1, tap_q};
          op.src     = iirdf_pkg::SRC_Y;
          op.neg     = 1'b1;
          op.zero    = (tap_q > fill_q);
          phase_d    = 1'b0;
          tap_d      = tap_q + 1'b1;
          ptr_d      = (ptr_q == HptrW'(MaxOrder - 1)) ? '0 : ptr_q + 1'b1;
        end
      end
      iirdf_pkg::ST_DRAIN: ;
      iirdf_pkg::ST_SCALE: begin
        scale_en = 1'b1;
      end
      iirdf_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          hist_we  = 1'b1;
          head_d   = new_head;
          fill_d   = (32'(fill_q) == MaxOrder) ? fill_q : fill_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iirdf_pkg::ST_IDLE;
      tap_q   <= '0;
      phase_q <= 1'b0;
      ptr_q   <= '0;
      head_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
    end
  end

  // Hold the sample for the whole computation
  always_ff @(posedge clk_i) begin
    if (in_fire && func_in == iirdf_pkg::FUNC_SAMPLE) begin
      sample_q <= sample_in_i;
    end
  end

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_y;
      out_sat_q  <= mac_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = out_data_q;
  assign saturated_o    = out_sat_q;

  // Numerator coefficients in the lower half, denominator in the upper half
  iirdf_ram #(
    .Width (iirdf_pkg::COEF_W),
    .Depth (CoefDepth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Circular history of {x, y}; entries beyond the fill count read as zero
  iirdf_ram #(
    .Width (HistW),
    .Depth (MaxOrder)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  iirdf_mac #(
    .MaxOrder (MaxOrder)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_clr_i (acc_clr),
    .op_i      (op),
    .coef_i    (coef_rdata),
    .hist_i    (hist_rdata),
    .sample_i  (sample_q),
    .frac_i    (frac_q),
    .scale_i   (scale_en),
    .busy_o    (mac_busy),
    .y_o       (mac_y),
    .sat_o     (mac_sat)
  );

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == iirdf_pkg::ST_DONE))
    else $error("output word appeared outside the completion step");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= MaxOrder)
    else $error("history fill count beyond depth");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iirdf_pkg::ST_IDLE |-> !mac_busy)
    else $error("accumulator pipeline busy while idle");

  a_sample_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && func_in == iirdf_pkg::FUNC_SAMPLE |=>
      state_q == iirdf_pkg::ST_TAP && tap_q == '0 && !phase_q)
    else $error("sample did not start at tap zero");
`endif

endmodule
